@@ design/fsa_pkg.sv @@
package fsa_pkg;

  localparam int POSITION_BITS = 24;
  localparam int QUAT_BITS = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN = 24;

  localparam int ANGLE_BITS = 16;
  localparam int ANGLE_MAX = 25736;
  localparam int ROUND_SHIFT = 16;

  localparam int DIFF_BITS = POSITION_BITS + 1;
  localparam int PROD_BITS = 2 * QUAT_BITS;
  localparam int MAT_BITS = PROD_BITS + 2;
  localparam int TERM_BITS = MAT_BITS + DIFF_BITS;
  localparam int LOCAL_BITS = TERM_BITS + 2;

  localparam int NORM_BITS = 30;
  localparam int SHIFT_SPAN = LOCAL_BITS - NORM_BITS;
  localparam int SHIFT_BITS = $clog2(SHIFT_SPAN + 1);
  localparam int SQR_BITS = 2 * NORM_BITS;
  localparam int SQ_BITS = SQR_BITS + 1;
  localparam int ROOT_BITS = NORM_BITS + 1;
  localparam int TRIAL_BITS = 2 * ROOT_BITS + 1;

  localparam int CX_BITS = NORM_BITS + 4;
  localparam int CZ_BITS = 33;

  localparam logic signed [CZ_BITS-1:0] ANGLE_LIMIT = CZ_BITS'(ANGLE_MAX) <<< ROUND_SHIFT;
  localparam logic signed [CZ_BITS-1:0] ROUND_HALF = CZ_BITS'(1) <<< (ROUND_SHIFT - 1);

  // atan(2^-i) in Q30 radians, truncated
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [QUAT_BITS-1:0]     palm_w;
    logic signed [QUAT_BITS-1:0]     palm_x;
    logic signed [QUAT_BITS-1:0]     palm_y;
    logic signed [QUAT_BITS-1:0]     palm_z;
    logic signed [POSITION_BITS-1:0] knuckle_x;
    logic signed [POSITION_BITS-1:0] knuckle_y;
    logic signed [POSITION_BITS-1:0] knuckle_z;
    logic signed [POSITION_BITS-1:0] tip_x;
    logic signed [POSITION_BITS-1:0] tip_y;
    logic signed [POSITION_BITS-1:0] tip_z;
  } fsa_pose_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] splay_angle;
    logic                         degenerate;
  } fsa_splay_t;

  typedef struct packed {
    logic vld;
    logic degen;
    logic neg;
  } fsa_tag_t;

endpackage

@@ design/fsa_rotate.sv @@
module fsa_rotate (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  pose_vld,
  input  fsa_pkg::fsa_pose_t                    pose,
  output logic                                  rot_vld,
  output logic signed [fsa_pkg::LOCAL_BITS-1:0] lx,
  output logic signed [fsa_pkg::LOCAL_BITS-1:0] ly,
  output logic signed [fsa_pkg::LOCAL_BITS-1:0] lz
);
  import fsa_pkg::*;

  logic [2:0] vld;

  logic signed [DIFF_BITS-1:0] dx1, dy1, dz1, dx2, dy2, dz2;
  logic signed [PROD_BITS-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [MAT_BITS-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [TERM_BITS-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rot_vld <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], pose_vld};
      rot_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // difference vector and quaternion products
      dx1 <= {pose.tip_x[POSITION_BITS-1], pose.tip_x}
           - {pose.knuckle_x[POSITION_BITS-1], pose.knuckle_x};
      dy1 <= {pose.tip_y[POSITION_BITS-1], pose.tip_y}
           - {pose.knuckle_y[POSITION_BITS-1], pose.knuckle_y};
      dz1 <= {pose.tip_z[POSITION_BITS-1], pose.tip_z}
           - {pose.knuckle_z[POSITION_BITS-1], pose.knuckle_z};
      ww <= pose.palm_w * pose.palm_w;
      xx <= pose.palm_x * pose.palm_x;
      yy <= pose.palm_y * pose.palm_y;
      zz <= pose.palm_z * pose.palm_z;
      xy <= pose.palm_x * pose.palm_y;
      wz <= pose.palm_w * pose.palm_z;
      xz <= pose.palm_x * pose.palm_z;
      wy <= pose.palm_w * pose.palm_y;
      yz <= pose.palm_y * pose.palm_z;
      wx <= pose.palm_w * pose.palm_x;

      // transposed rotation matrix scaled by |q|^2
      m00 <= MAT_BITS'(ww) + MAT_BITS'(xx) - MAT_BITS'(yy) - MAT_BITS'(zz);
      m01 <= (MAT_BITS'(xy) + MAT_BITS'(wz)) <<< 1;
      m02 <= (MAT_BITS'(xz) - MAT_BITS'(wy)) <<< 1;
      m10 <= (MAT_BITS'(xy) - MAT_BITS'(wz)) <<< 1;
      m11 <= MAT_BITS'(ww) - MAT_BITS'(xx) + MAT_BITS'(yy) - MAT_BITS'(zz);
      m12 <= (MAT_BITS'(yz) + MAT_BITS'(wx)) <<< 1;
      m20 <= (MAT_BITS'(xz) + MAT_BITS'(wy)) <<< 1;
      m21 <= (MAT_BITS'(yz) - MAT_BITS'(wx)) <<< 1;
      m22 <= MAT_BITS'(ww) - MAT_BITS'(xx) - MAT_BITS'(yy) + MAT_BITS'(zz);
      dx2 <= dx1;
      dy2 <= dy1;
      dz2 <= dz1;

      p00 <= m00 * dx2;
      p01 <= m01 * dy2;
      p02 <= m02 * dz2;
      p10 <= m10 * dx2;
      p11 <= m11 * dy2;
      p12 <= m12 * dz2;
      p20 <= m20 * dx2;
      p21 <= m21 * dy2;
      p22 <= m22 * dz2;

      lx <= LOCAL_BITS'(p00) + LOCAL_BITS'(p01) + LOCAL_BITS'(p02);
      ly <= LOCAL_BITS'(p10) + LOCAL_BITS'(p11) + LOCAL_BITS'(p12);
      lz <= LOCAL_BITS'(p20) + LOCAL_BITS'(p21) + LOCAL_BITS'(p22);
    end
  end

endmodule

@@ design/fsa_sqrt_cell.sv @@
module fsa_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  fsa_pkg::fsa_tag_t                 tag_in,
  input  logic [fsa_pkg::SQ_BITS-1:0]       rem_in,
  input  logic [fsa_pkg::ROOT_BITS-1:0]     root_in,
  input  logic [fsa_pkg::NORM_BITS-1:0]     ax_in,
  output fsa_pkg::fsa_tag_t                 tag_out,
  output logic [fsa_pkg::SQ_BITS-1:0]       rem_out,
  output logic [fsa_pkg::ROOT_BITS-1:0]     root_out,
  output logic [fsa_pkg::NORM_BITS-1:0]     ax_out
);
  import fsa_pkg::*;

  logic [TRIAL_BITS-1:0] trial;
  logic [TRIAL_BITS-1:0] rem_wide;
  logic                  fit;

  // (root + 2^K)^2 - root^2
  assign trial = (TRIAL_BITS'(root_in) << (K + 1)) + (TRIAL_BITS'(1) << (2 * K));
  assign rem_wide = TRIAL_BITS'(rem_in);
  assign fit = rem_wide >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fit ? SQ_BITS'(rem_wide - trial) : rem_in;
      root_out <= fit ? (root_in | (ROOT_BITS'(1) << K)) : root_in;
      ax_out <= ax_in;
    end
  end

endmodule

@@ design/fsa_cordic_cell.sv @@
module fsa_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  fsa_pkg::fsa_tag_t                  tag_in,
  input  logic signed [fsa_pkg::CX_BITS-1:0] cx_in,
  input  logic signed [fsa_pkg::CX_BITS-1:0] cy_in,
  input  logic signed [fsa_pkg::CZ_BITS-1:0] cz_in,
  output fsa_pkg::fsa_tag_t                  tag_out,
  output logic signed [fsa_pkg::CX_BITS-1:0] cx_out,
  output logic signed [fsa_pkg::CX_BITS-1:0] cy_out,
  output logic signed [fsa_pkg::CZ_BITS-1:0] cz_out
);
  import fsa_pkg::*;

  logic [CX_BITS-1:0]        cx_mag, cy_mag;
  logic signed [CX_BITS-1:0] sx, sy;
  logic signed [CZ_BITS-1:0] step_ang;
  logic                      rot_cw;

  // shifts truncate toward zero
  assign cx_mag = cx_in[CX_BITS-1] ? CX_BITS'(-cx_in) : CX_BITS'(cx_in);
  assign cy_mag = cy_in[CX_BITS-1] ? CX_BITS'(-cy_in) : CX_BITS'(cy_in);
  assign sx = cx_in[CX_BITS-1] ? -$signed(cx_mag >> IDX) : $signed(cx_mag >> IDX);
  assign sy = cy_in[CX_BITS-1] ? -$signed(cy_mag >> IDX) : $signed(cy_mag >> IDX);
  assign step_ang = CZ_BITS'(ATAN_Q30[IDX]);
  assign rot_cw = !cy_in[CX_BITS-1] && (cy_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rot_cw) begin
        cx_out <= cx_in + sy;
        cy_out <= cy_in - sx;
        cz_out <= cz_in + step_ang;
      end else begin
        cx_out <= cx_in - sy;
        cy_out <= cy_in + sx;
        cz_out <= cz_in - step_ang;
      end
    end
  end

  a_cx_positive: assert property (@(posedge clk) disable iff (rst)
    tag_out.vld |-> !cx_out[CX_BITS-1])
    else $error("cordic x went negative");

endmodule

@@ design/finger_splay_angle_core.sv @@
// Pose path: rotation, normalization, square-root cells, CORDIC cells, output register.
// Throughput: one pose per cycle; the whole pipeline advances together and holds
// only while a finished result is stalled at the output register.
// Reset (rst, synchronous): clears every stage valid and the output valid;
// data registers keep whatever they hold.
module finger_splay_angle_core #(
  parameter int CORDIC_STAGES = fsa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pose_valid,
  output logic                pose_stall,
  input  fsa_pkg::fsa_pose_t  pose,
  output logic                splay_valid,
  input  logic                splay_stall,
  output fsa_pkg::fsa_splay_t splay
);
  import fsa_pkg::*;

  // Advance everything unless the output transaction is waiting.
  logic en;
  assign en = !(splay_valid && splay_stall);
  assign pose_stall = !en;

  // Rotate tip - knuckle into the palm frame.
  logic                         rot_vld;
  logic signed [LOCAL_BITS-1:0] lx, ly, lz;

  fsa_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .pose_vld (pose_valid),
    .pose     (pose),
    .rot_vld  (rot_vld),
    .lx       (lx),
    .ly       (ly),
    .lz       (lz)
  );

  // Magnitudes, zero test and sign of lx.
  fsa_tag_t              tag1, tag2, tag3, tag4, tag5;
  logic [LOCAL_BITS-1:0] ax1, ay1, az1, ax2, ay2, az2;
  logic [LOCAL_BITS-1:0] norm_or;
  logic [SHIFT_BITS-1:0] shift_next, shift2, shift3;
  logic [NORM_BITS-1:0]  ax3, ay3, az3, ax4, ax5;
  logic [NORM_BITS-1:0]  norm_or3;
  logic [SQR_BITS-1:0]   ysq4, zsq4;
  logic [SQ_BITS-1:0]    nsum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
      tag5 <= '0;
    end else if (en) begin
      tag1.vld <= rot_vld;
      tag1.degen <= (lx == '0) && (ly == '0) && (lz == '0);
      tag1.neg <= !lx[LOCAL_BITS-1] && (lx != '0);
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
      tag5 <= tag4;
    end
  end

  // The bit length of the OR equals that of the largest magnitude, so
  // the normalizing shift comes from a priority encode over the top bits.
  assign norm_or = ax1 | ay1 | az1;

  always_comb begin
    shift_next = '0;
    for (int j = 0; j < SHIFT_SPAN; j++) begin
      if (norm_or[NORM_BITS + j]) begin
        shift_next = SHIFT_BITS'(j + 1);
      end
    end
  end

  assign norm_or3 = ax3 | ay3 | az3;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= lx[LOCAL_BITS-1] ? LOCAL_BITS'(-lx) : LOCAL_BITS'(lx);
      ay1 <= ly[LOCAL_BITS-1] ? LOCAL_BITS'(-ly) : LOCAL_BITS'(ly);
      az1 <= lz[LOCAL_BITS-1] ? LOCAL_BITS'(-lz) : LOCAL_BITS'(lz);

      ax2 <= ax1;
      ay2 <= ay1;
      az2 <= az1;
      shift2 <= shift_next;

      // bring all three below 2^30, truncating
      ax3 <= NORM_BITS'(ax2 >> shift2);
      ay3 <= NORM_BITS'(ay2 >> shift2);
      az3 <= NORM_BITS'(az2 >> shift2);
      shift3 <= shift2;

      ysq4 <= SQR_BITS'(ay3) * SQR_BITS'(ay3);
      zsq4 <= SQR_BITS'(az3) * SQR_BITS'(az3);
      ax4 <= ax3;

      nsum5 <= SQ_BITS'(ysq4) + SQ_BITS'(zsq4);
      ax5 <= ax4;
    end
  end

  // Integer square root: one result bit per cell, most significant first.
  fsa_tag_t             sq_tag  [ROOT_BITS+1];
  logic [SQ_BITS-1:0]   sq_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root [ROOT_BITS+1];
  logic [NORM_BITS-1:0] sq_ax   [ROOT_BITS+1];

  assign sq_tag[0] = tag5;
  assign sq_rem[0] = nsum5;
  assign sq_root[0] = '0;
  assign sq_ax[0] = ax5;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    fsa_sqrt_cell #(.K(ROOT_BITS - 1 - g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tag_in   (sq_tag[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .ax_in    (sq_ax[g]),
      .tag_out  (sq_tag[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .ax_out   (sq_ax[g+1])
    );
  end

  // Vectoring CORDIC from (root, |lx|): one micro-rotation per cell.
  fsa_tag_t                  co_tag [CORDIC_STAGES+1];
  logic signed [CX_BITS-1:0] co_x   [CORDIC_STAGES+1];
  logic signed [CX_BITS-1:0] co_y   [CORDIC_STAGES+1];
  logic signed [CZ_BITS-1:0] co_z   [CORDIC_STAGES+1];

  assign co_tag[0] = sq_tag[ROOT_BITS];
  assign co_x[0] = CX_BITS'(sq_root[ROOT_BITS]);
  assign co_y[0] = CX_BITS'(sq_ax[ROOT_BITS]);
  assign co_z[0] = '0;

  for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
    fsa_cordic_cell #(.IDX(c)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tag_in  (co_tag[c]),
      .cx_in   (co_x[c]),
      .cy_in   (co_y[c]),
      .cz_in   (co_z[c]),
      .tag_out (co_tag[c+1]),
      .cx_out  (co_x[c+1]),
      .cy_out  (co_y[c+1]),
      .cz_out  (co_z[c+1])
    );
  end

  // Clamp to [0, quarter turn], round half up to 1/16384 rad, apply sign.
  fsa_tag_t                     fin_tag;
  logic signed [CZ_BITS-1:0]    cz_fin, cz_clamp, cz_round;
  logic signed [ANGLE_BITS-1:0] ang_mag, ang_signed;

  assign fin_tag = co_tag[CORDIC_STAGES];
  assign cz_fin = co_z[CORDIC_STAGES];

  always_comb begin
    if (cz_fin[CZ_BITS-1]) begin
      cz_clamp = '0;
    end else if (cz_fin > ANGLE_LIMIT) begin
      cz_clamp = ANGLE_LIMIT;
    end else begin
      cz_clamp = cz_fin;
    end
  end

  assign cz_round = cz_clamp + ROUND_HALF;
  assign ang_mag = cz_round[ROUND_SHIFT +: ANGLE_BITS];
  assign ang_signed = fin_tag.neg ? -ang_mag : ang_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      splay_valid <= 1'b0;
    end else if (en) begin
      splay_valid <= fin_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      splay.splay_angle <= fin_tag.degen ? '0 : ang_signed;
      splay.degenerate <= fin_tag.degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    splay_valid && splay.degenerate |-> splay.splay_angle == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    splay_valid |-> (splay.splay_angle <= ANGLE_BITS'(ANGLE_MAX))
                 && (splay.splay_angle >= -ANGLE_BITS'(ANGLE_MAX)))
    else $error("splay angle beyond a quarter turn");

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    tag3.vld && (shift3 != '0) |-> norm_or3[NORM_BITS-1])
    else $error("normalizing shift too large");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    sq_tag[ROOT_BITS].vld |->
      sq_rem[ROOT_BITS] <= (SQ_BITS'(sq_root[ROOT_BITS]) << 1))
    else $error("square root remainder too large");

endmodule

@@ bench/fsa_splay_checker.sv @@
module fsa_splay_checker #(
  parameter int CORDIC_STAGES = fsa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pose_valid,
  input  logic                pose_stall,
  input  fsa_pkg::fsa_pose_t  pose,
  input  logic                splay_valid,
  input  logic                splay_stall,
  input  fsa_pkg::fsa_splay_t splay,
  output int                  errors,
  output int                  pending,
  output int                  checked
);
  import fsa_pkg::*;

  fsa_splay_t splay_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint shift_mag(input longint v, input int s);
    longint unsigned m;
    if (v < 0) begin
      m = -v;
      return -longint'(m >> s);
    end
    return longint'(longint'(v) >>> s);
  endfunction

  function automatic fsa_splay_t splay_of_pose(input fsa_pose_t p);
    fsa_splay_t res;
    longint w, x, y, z, dx, dy, dz, ww, xx, yy, zz, lx, ly, lz;
    longint unsigned ax, ay, az, m, r;
    longint cx, cy, cz, sx, sy, ang;
    int s;
    w = p.palm_w; x = p.palm_x; y = p.palm_y; z = p.palm_z;
    dx = longint'(p.tip_x) - longint'(p.knuckle_x);
    dy = longint'(p.tip_y) - longint'(p.knuckle_y);
    dz = longint'(p.tip_z) - longint'(p.knuckle_z);
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    // rotate by the conjugate, scaled by |q|^2
    lx = (ww + xx - yy - zz) * dx + 2 * (x * y + w * z) * dy + 2 * (x * z - w * y) * dz;
    ly = 2 * (x * y - w * z) * dx + (ww - xx + yy - zz) * dy + 2 * (y * z + w * x) * dz;
    lz = 2 * (x * z + w * y) * dx + 2 * (y * z - w * x) * dy + (ww - xx - yy + zz) * dz;
    res = '0;
    if (lx == 0 && ly == 0 && lz == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    ax = lx < 0 ? -lx : lx;
    ay = ly < 0 ? -ly : ly;
    az = lz < 0 ? -lz : lz;
    m = ax > ay ? ax : ay;
    if (az > m) m = az;
    s = 0;
    while ((m >> s) >= (64'd1 << NORM_BITS)) s++;
    ax >>= s; ay >>= s; az >>= s;
    r = int_sqrt(ay * ay + az * az);
    cx = r; cy = ax; cz = 0;
    for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
      sx = shift_mag(cx, i);
      sy = shift_mag(cy, i);
      if (cy > 0) begin
        cx += sy; cy -= sx; cz += longint'(ATAN_Q30[i]);
      end else begin
        cx -= sy; cy += sx; cz -= longint'(ATAN_Q30[i]);
      end
    end
    if (cz < 0) cz = 0;
    if (cz > (longint'(ANGLE_MAX) << ROUND_SHIFT)) cz = longint'(ANGLE_MAX) << ROUND_SHIFT;
    ang = (cz + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (lx > 0) ang = -ang;
    res.splay_angle = ang[ANGLE_BITS-1:0];
    return res;
  endfunction

  assign pending = splay_q.size();

  always @(posedge clk) begin
    fsa_splay_t exp_s;
    if (rst) begin
      splay_q.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (splay_valid && !splay_stall) begin
        if (splay_q.size() == 0) begin
          $display("%0t: unexpected splay result angle=%0d degenerate=%0b",
                   $time, splay.splay_angle, splay.degenerate);
          errors <= errors + 1;
        end else begin
          exp_s = splay_q.pop_front();
          checked <= checked + 1;
          if (exp_s.splay_angle !== splay.splay_angle) begin
            $display("%0t: splay_angle expected %0d actual %0d",
                     $time, exp_s.splay_angle, splay.splay_angle);
            errors <= errors + 1;
          end else if (exp_s.degenerate !== splay.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b",
                     $time, exp_s.degenerate, splay.degenerate);
            errors <= errors + 1;
          end
        end
      end
      if (pose_valid && !pose_stall) splay_q.push_back(splay_of_pose(pose));
    end
  end

endmodule

@@ bench/tb_finger_splay_angle_core.sv @@
module tb_finger_splay_angle_core;
  import fsa_pkg::*;

  logic       clk;
  logic       rst;
  logic       pose_valid;
  logic       pose_stall;
  fsa_pose_t  pose;
  logic       splay_valid;
  logic       splay_stall;
  fsa_splay_t splay;

  int errors;
  int pending;
  int checked;
  int send_idle;   // percent of cycles the sender holds off
  int recv_idle;   // percent of cycles the receiver stalls
  int sent;
  int degen_sent;

  localparam int QMAX = 16384;

  finger_splay_angle_core u_top (
    .clk        (clk),
    .rst        (rst),
    .pose_valid (pose_valid),
    .pose_stall (pose_stall),
    .pose       (pose),
    .splay_valid(splay_valid),
    .splay_stall(splay_stall),
    .splay      (splay)
  );

  fsa_splay_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pose_valid (pose_valid),
    .pose_stall (pose_stall),
    .pose       (pose),
    .splay_valid(splay_valid),
    .splay_stall(splay_stall),
    .splay      (splay),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    if (rst) splay_stall <= 1'b0;
    else splay_stall <= ($urandom_range(99) < recv_idle);
  end

  // Hold a transaction on the pose channel until it is taken.
  task automatic send_pose(input fsa_pose_t p);
    while ($urandom_range(99) < send_idle) begin
      pose_valid <= 1'b0;
      @(posedge clk);
    end
    pose_valid <= 1'b1;
    pose <= p;
    @(posedge clk);
    while (pose_stall) @(posedge clk);
    sent++;
    if (p.tip_x == p.knuckle_x && p.tip_y == p.knuckle_y && p.tip_z == p.knuckle_z)
      degen_sent++;
  endtask

  function automatic logic signed [15:0] rand_quat_comp();
    return 16'(int'($urandom_range(2 * QMAX)) - QMAX);
  endfunction

  function automatic logic signed [23:0] rand_pos();
    return 24'($urandom);
  endfunction

  // Build a random pose: mostly random quaternion components in [-QMAX, QMAX] and modest
  // finger vectors, with full-range positions, exact zero vectors, axis-aligned cases and zero quaternions mixed in.
  function automatic fsa_pose_t rand_pose();
    fsa_pose_t p;
    int kind;
    int dspan;
    kind = $urandom_range(99);
    p.palm_w = rand_quat_comp();
    p.palm_x = rand_quat_comp();
    p.palm_y = rand_quat_comp();
    p.palm_z = rand_quat_comp();
    if (kind < 8) begin
      // one axis only, or identity
      p.palm_w = 16'(QMAX);
      p.palm_x = '0;
      p.palm_y = '0;
      p.palm_z = '0;
      case ($urandom_range(3))
        0: p.palm_w = -16'(QMAX);
        1: p.palm_x = 16'(QMAX);
        2: p.palm_y = rand_quat_comp();
        default: ;
      endcase
    end else if (kind < 10) begin
      p.palm_w = '0;
      p.palm_x = '0;
      p.palm_y = '0;
      p.palm_z = '0;
    end
    p.knuckle_x = rand_pos();
    p.knuckle_y = rand_pos();
    p.knuckle_z = rand_pos();
    if (kind >= 10 && kind < 40) begin
      p.tip_x = rand_pos();
      p.tip_y = rand_pos();
      p.tip_z = rand_pos();
    end else begin
      dspan = 1 << $urandom_range(16);
      p.tip_x = p.knuckle_x + 24'(int'($urandom_range(2 * dspan)) - dspan);
      p.tip_y = p.knuckle_y + 24'(int'($urandom_range(2 * dspan)) - dspan);
      p.tip_z = p.knuckle_z + 24'(int'($urandom_range(2 * dspan)) - dspan);
      if ($urandom_range(19) == 0) begin
        p.tip_x = p.knuckle_x;
        p.tip_y = p.knuckle_y;
        p.tip_z = p.knuckle_z;
      end else if ($urandom_range(9) == 0) begin
        p.tip_y = p.knuckle_y;
        p.tip_z = p.knuckle_z;
      end
    end
    return p;
  endfunction

  function automatic fsa_pose_t make_pose(input int w, input int x, input int y, input int z,
                                          input int kx, input int ky, input int kz,
                                          input int tx, input int ty, input int tz);
    fsa_pose_t p;
    p.palm_w = 16'(w);
    p.palm_x = 16'(x);
    p.palm_y = 16'(y);
    p.palm_z = 16'(z);
    p.knuckle_x = 24'(kx);
    p.knuckle_y = 24'(ky);
    p.knuckle_z = 24'(kz);
    p.tip_x = 24'(tx);
    p.tip_y = 24'(ty);
    p.tip_z = 24'(tz);
    return p;
  endfunction

  initial begin
    fsa_pose_t directed[$];
    rst = 1'b1;
    pose_valid = 1'b0;
    pose = '0;
    send_idle = 0;
    recv_idle = 0;
    sent = 0;
    degen_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector, zero quaternion, palm normal both ways, in-plane, extremes
    directed.push_back(make_pose(QMAX, 0, 0, 0, 100, 200, 300, 100, 200, 300));
    directed.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 5000, -7000, 9000));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, 65536, 0, 0));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, -65536, 0, 0));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, 0, 65536, 0));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, 0, 0, -65536));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, 1000, 1000, 0));
    directed.push_back(make_pose(QMAX, 0, 0, 0, -8388608, -8388608, -8388608,
                                 8388607, 8388607, 8388607));
    directed.push_back(make_pose(-QMAX, 0, 0, 0, 8388607, -8388608, 8388607,
                                 -8388608, 8388607, -8388608));
    directed.push_back(make_pose(-QMAX, -QMAX, -QMAX, -QMAX, -8388608, 0, 8388607,
                                 8388607, 0, -8388608));
    directed.push_back(make_pose(QMAX, QMAX, QMAX, QMAX, 8388607, 8388607, 8388607,
                                 -8388608, -8388608, -8388608));
    directed.push_back(make_pose(0, QMAX, 0, 0, 0, 0, 0, 3000, 4000, 0));
    directed.push_back(make_pose(0, 0, -QMAX, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_pose(0, 0, 0, QMAX, 0, 0, 0, 0, 1, 1));
    directed.push_back(make_pose(11585, 11585, 0, 0, 10, 20, 30, 40, 50, 60));
    directed.push_back(make_pose(3, -2, 1, 0, 0, 0, 0, 123456, -654321, 7));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_pose(QMAX, 0, 0, 0, 0, 0, 0, -1, 1, 0));
    foreach (directed[i]) send_pose(directed[i]);

    // drain before going random
    pose_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 24; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < 360; n++) send_pose(rand_pose());
      // hold off the sender until the pipeline is empty
      pose_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    pose_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d poses (%0d with tip on knuckle), %0d splay results compared,",
             sent, degen_sent, checked);
    $display("under sender and receiver idling of 24/61, 61/24 and 0/0 percent.");
    if (errors == 0 && pending == 0) begin
      $display("finger_splay_angle_core test passed");
    end else begin
      $display("finger_splay_angle_core test failed");
    end
    $finish;
  end

  // Watchdog: fail and end the run if it has not finished by the time limit.
  initial begin
    #(12 * 400000);
    $display("finger_splay_angle_core test failed");
    $finish;
  end

endmodule
